FILE: sv/vsp_pkg.sv
// ----------------------------------------------------------------------------
// vsp_pkg
// Shared types and constants for the video scroll and sprite register port.
// ----------------------------------------------------------------------------
package vsp_pkg;

    // Item function codes
    typedef enum logic [2:0] {
        FUNC_WRITE      = 3'd0,
        FUNC_READ       = 3'd1,
        FUNC_SET_STATUS = 3'd2,
        FUNC_PRERENDER  = 3'd3,
        FUNC_END_FRAME  = 3'd4
    } func_t;

    // Register numbers
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;

    // Sprite attribute store geometry
    localparam int OAM_DEPTH = 256;
    localparam int OAM_AW    = $clog2(OAM_DEPTH);

    // Address and flag constants
    localparam int         VA_W            = 15;
    localparam logic [14:0] A12_MASK_RESET = 15'h1000;
    localparam logic [7:0]  STATUS_RESET   = 8'h80;
    localparam logic [7:0]  STATUS_KEEP    = 8'h1F;
    localparam logic [7:0]  OAM_ATTR_MASK  = 8'hE3;
    localparam logic [1:0]  OAM_ATTR_BYTE  = 2'd2;
    localparam int          MASK_RENDER_BIT = 3;
    localparam logic [7:0]  LINE_END_LOW   = 8'hFE;
    localparam logic [14:0] ADDR_STEP      = 15'd2;
    localparam logic [14:0] NT_TOGGLE      = 15'h0400;
    localparam logic [14:0] LINE_WRAP_BACK = 15'h001E;

    // Store access request from the register logic
    typedef struct packed {
        logic              we;
        logic              re;
        logic [OAM_AW-1:0] addr;
        logic [7:0]        wdata;
    } oam_req_t;

    // Per-item result, less the store read data
    typedef struct packed {
        logic [7:0] rd;
        logic       a12_clk;
        logic       nmi;
        logic       sel_mem;
        logic       mask_attr;
    } item_res_t;

endpackage

FILE: sv/video_scroll_and_oam_register_port_unit.sv
// ----------------------------------------------------------------------------
// video_scroll_and_oam_register_port_unit
// Register front end of a tile video processor: scroll/address registers,
// status flags and a 256-byte sprite attribute store.
// ----------------------------------------------------------------------------
// One item is taken per clock and its result appears in the output register
// the cycle after the transfer; a new item is taken whenever that register is
// empty or being drained in the same cycle, so a steady flow runs at one item
// per clock. Sprite store reads go through the single-port store RAM, whose
// registered read lines up with the output register. Unwritten store entries
// read as zero after reset with no clearing pass. The user must write a12_mask
// register via cfg_wr_en/cfg_wr_data only while the port is idle; unenforced.
module video_scroll_and_oam_register_port_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  func,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic        a12_clock,
    output logic        nmi_request,
    output logic [14:0] current_addr,
    output logic [2:0]  fine_scroll_x
);
    import vsp_pkg::*;

    logic      fire;
    logic      out_valid_reg, out_valid_next;
    oam_req_t  oam_req;
    item_res_t res;
    item_res_t res_reg;
    logic [7:0] oam_rdata;

    // Input transfer when the output slot is free or draining
    assign in_stall = out_valid_reg & out_stall;
    assign fire     = in_valid & ~in_stall;

    vsp_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .func       (func),
        .reg_index  (reg_index),
        .data       (data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .oam_req    (oam_req),
        .res        (res),
        .video_addr (current_addr),
        .fine_x     (fine_scroll_x)
    );

    vsp_oam_ram u_oam (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (oam_req),
        .rdata(oam_rdata)
    );

    // Output valid
    assign out_valid_next = fire | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    // Store data joins at the output; attribute byte drops unused bits
    always_comb
    begin
        if (res_reg.sel_mem)
        begin
            read_data = res_reg.mask_attr ? (oam_rdata & OAM_ATTR_MASK) : oam_rdata;
        end
        else
        begin
            read_data = res_reg.rd;
        end
    end

    assign out_valid   = out_valid_reg;
    assign a12_clock   = res_reg.a12_clk;
    assign nmi_request = res_reg.nmi;

endmodule

FILE: sv/vsp_oam_ram.sv
// ----------------------------------------------------------------------------
// vsp_oam_ram
// Sprite attribute store: single-port synchronous RAM, registered read,
// per-entry valid bits so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module vsp_oam_ram (
    input  logic             clk,
    input  logic             rst_n,
    input  vsp_pkg::oam_req_t req,
    output logic [7:0]       rdata
);
    import vsp_pkg::*;

    logic [7:0]           oam_mem [OAM_DEPTH];
    logic [OAM_DEPTH-1:0] valid_reg;
    logic [7:0]           mem_q_reg;
    logic                 hit_q_reg;

    // Array write and registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            oam_mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            mem_q_reg <= oam_mem[req.addr];
        end
    end

    // Valid bits and read hit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_q_reg <= 1'b0;
        end
        else
        begin
            if (req.we)
            begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.re)
            begin
                hit_q_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rdata = hit_q_reg ? mem_q_reg : 8'd0;

    // Never-written entry reads as zero
    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        req.re && !req.we && !valid_reg[req.addr] |=> rdata == 8'd0)
        else $error("unwritten store entry read nonzero");

endmodule

FILE: sv/vsp_regs.sv
// ----------------------------------------------------------------------------
// vsp_regs
// Control, mask, status, scroll and address registers; decodes each item,
// updates state and issues sprite store accesses.
// ----------------------------------------------------------------------------
module vsp_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [2:0]          func,
    input  logic [2:0]          reg_index,
    input  logic [7:0]          data,
    input  logic                cfg_wr_en,
    input  logic [14:0]         cfg_wr_data,
    output vsp_pkg::oam_req_t   oam_req,
    output vsp_pkg::item_res_t  res,
    output logic [14:0]         video_addr,
    output logic [2:0]          fine_x
);
    import vsp_pkg::*;

    func_t             func_code;
    logic [14:0]       a12_mask_reg;
    logic [7:0]        control_reg, control_next;
    logic [7:0]        mask_reg, mask_next;
    logic [7:0]        status_reg, status_next;
    logic [OAM_AW-1:0] sprite_addr_reg, sprite_addr_next;
    logic              toggle_reg, toggle_next;
    logic [14:0]       temp_reg, temp_next;
    logic [14:0]       video_reg, video_next;
    logic [2:0]        fine_x_reg, fine_x_next;
    logic [14:0]       addr_load;

    assign func_code = func_t'(func);
    assign addr_load = {temp_reg[14:8], data};

    // Item decode and next state
    always_comb
    begin
        control_next     = control_reg;
        mask_next        = mask_reg;
        status_next      = status_reg;
        sprite_addr_next = sprite_addr_reg;
        toggle_next      = toggle_reg;
        temp_next        = temp_reg;
        video_next       = video_reg;
        fine_x_next      = fine_x_reg;
        res              = '0;
        oam_req.we       = 1'b0;
        oam_req.re       = 1'b0;
        oam_req.addr     = sprite_addr_reg;
        oam_req.wdata    = data;
        if (fire)
        begin
            case (func_code)
                FUNC_WRITE:
                begin
                    case (reg_index)
                        REG_CTRL:
                        begin
                            control_next     = data;
                            temp_next[11:10] = data[1:0];
                        end
                        REG_MASK:
                        begin
                            mask_next = data;
                        end
                        REG_OAM_ADDR:
                        begin
                            sprite_addr_next = data[OAM_AW-1:0];
                        end
                        REG_OAM_DATA:
                        begin
                            oam_req.we       = 1'b1;
                            sprite_addr_next = sprite_addr_reg + OAM_AW'(1);
                        end
                        REG_SCROLL:
                        begin
                            toggle_next = ~toggle_reg;
                            if (!toggle_reg)
                            begin
                                fine_x_next    = data[2:0];
                                temp_next[4:0] = data[7:3];
                            end
                            else
                            begin
                                temp_next[9:5]   = data[7:3];
                                temp_next[14:12] = data[2:0];
                            end
                        end
                        REG_ADDR:
                        begin
                            toggle_next = ~toggle_reg;
                            if (!toggle_reg)
                            begin
                                temp_next[14:8] = {1'b0, data[5:0]};
                            end
                            else
                            begin
                                temp_next[7:0] = data;
                                video_next     = addr_load;
                                // mapper clock on a masked bit rising
                                res.a12_clk = |(addr_load & ~video_reg & a12_mask_reg);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                FUNC_READ:
                begin
                    case (reg_index)
                        REG_STATUS:
                        begin
                            res.rd         = status_reg;
                            status_next[7] = 1'b0;
                            toggle_next    = 1'b0;
                        end
                        REG_OAM_DATA:
                        begin
                            oam_req.re    = 1'b1;
                            res.sel_mem   = 1'b1;
                            res.mask_attr = (sprite_addr_reg[1:0] == OAM_ATTR_BYTE);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                FUNC_SET_STATUS:
                begin
                    status_next = status_reg | data;
                    res.nmi     = data[7] & control_reg[7];
                end
                FUNC_PRERENDER:
                begin
                    status_next = status_reg & STATUS_KEEP;
                end
                FUNC_END_FRAME:
                begin
                    // frame-end address step while rendering is on
                    if (mask_reg[MASK_RENDER_BIT])
                    begin
                        if (video_reg[7:0] < LINE_END_LOW)
                        begin
                            video_next = video_reg + ADDR_STEP;
                        end
                        else
                        begin
                            video_next = (video_reg ^ NT_TOGGLE) - LINE_WRAP_BACK;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a12_mask_reg    <= A12_MASK_RESET;
            control_reg     <= '0;
            mask_reg        <= '0;
            status_reg      <= STATUS_RESET;
            sprite_addr_reg <= '0;
            toggle_reg      <= 1'b0;
            temp_reg        <= '0;
            video_reg       <= '0;
            fine_x_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                a12_mask_reg <= cfg_wr_data;
            end
            control_reg     <= control_next;
            mask_reg        <= mask_next;
            status_reg      <= status_next;
            sprite_addr_reg <= sprite_addr_next;
            toggle_reg      <= toggle_next;
            temp_reg        <= temp_next;
            video_reg       <= video_next;
            fine_x_reg      <= fine_x_next;
        end
    end

    assign video_addr = video_reg;
    assign fine_x     = fine_x_reg;

    // First address write leaves the toggle set
    a_addr_first_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && func_code == FUNC_WRITE && reg_index == REG_ADDR && !toggle_reg
        |=> toggle_reg)
        else $error("toggle not set after first address write");

    // Status read clears vblank and the toggle
    a_status_read_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && func_code == FUNC_READ && reg_index == REG_STATUS
        |=> !status_reg[7] && !toggle_reg)
        else $error("status read did not clear vblank or toggle");

    // A mapper clock always comes with an address change
    a_a12_changes_addr: assert property (@(posedge clk) disable iff (!rst_n)
        res.a12_clk |=> video_reg != $past(video_reg))
        else $error("a12 clock without address change");

endmodule

FILE: sim/vsp_port_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vsp_port_checker
// Watches both channels and the a12_mask write port of the video scroll and
// sprite register port. It keeps its own copy of the register state and
// predicts the result of every input transfer. Each output transfer is then
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module vsp_port_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [14:0] cfg_wr_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  func,
    input  logic [2:0]  reg_index,
    input  logic [7:0]  data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  read_data,
    input  logic        a12_clock,
    input  logic        nmi_request,
    input  logic [14:0] current_addr,
    input  logic [2:0]  fine_scroll_x,
    output int          pending,
    output int          mismatches,
    output int          checked
);
    import vsp_pkg::*;

    // One predicted result of the port
    typedef struct packed {
        logic [7:0]  rd;
        logic        a12;
        logic        nmi;
        logic [14:0] addr;
        logic [2:0]  fx;
    } port_result_t;

    // Shadow register state
    logic [14:0] a12_mask_q;
    logic [7:0]  ctrl_q;
    logic [7:0]  render_mask_q;
    logic [7:0]  status_q;
    logic [7:0]  oam_ptr;
    logic [7:0]  oam_mem [OAM_DEPTH];
    logic        toggle_q;
    logic [14:0] tmp_addr;
    logic [14:0] vid_addr;
    logic [2:0]  fine_x_q;

    port_result_t predicted_results[$];
    int errors;
    int checked_n;

    // One line per mismatch
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // Apply one item to the shadow state and work out its result
    task automatic step_register_port(input logic [2:0] f, input logic [2:0] r,
                                      input logic [7:0] d, output port_result_t res);
        logic [14:0] rising;
        res = '0;
        case (f)
            FUNC_WRITE:
            begin
                case (r)
                    REG_CTRL:
                    begin
                        tmp_addr[11:10] = d[1:0];
                        ctrl_q = d;
                    end
                    REG_MASK:     render_mask_q = d;
                    REG_OAM_ADDR: oam_ptr = d;
                    REG_OAM_DATA:
                    begin
                        oam_mem[oam_ptr] = d;
                        oam_ptr = oam_ptr + 8'd1;
                    end
                    REG_SCROLL:
                    begin
                        toggle_q = ~toggle_q;
                        if (toggle_q)
                        begin
                            fine_x_q = d[2:0];
                            tmp_addr[4:0] = d[7:3];
                        end
                        else
                        begin
                            tmp_addr[9:5] = d[7:3];
                            tmp_addr[14:12] = d[2:0];
                        end
                    end
                    REG_ADDR:
                    begin
                        toggle_q = ~toggle_q;
                        if (toggle_q)
                        begin
                            tmp_addr[13:8] = d[5:0];
                            tmp_addr[14] = 1'b0;
                        end
                        else
                        begin
                            // masked bits clear in the old address may rise
                            rising = ~vid_addr & a12_mask_q;
                            tmp_addr[7:0] = d;
                            vid_addr = tmp_addr;
                            res.a12 = |(tmp_addr & rising);
                        end
                    end
                    default: ;
                endcase
            end
            FUNC_READ:
            begin
                if (r == REG_STATUS)
                begin
                    res.rd = status_q;
                    status_q[7] = 1'b0;
                    toggle_q = 1'b0;
                end
                else if (r == REG_OAM_DATA)
                begin
                    res.rd = oam_mem[oam_ptr];
                    if (oam_ptr[1:0] == OAM_ATTR_BYTE)
                        res.rd = res.rd & OAM_ATTR_MASK;
                end
            end
            FUNC_SET_STATUS:
            begin
                status_q = status_q | d;
                res.nmi = d[7] & ctrl_q[7];
            end
            FUNC_PRERENDER: status_q = status_q & STATUS_KEEP;
            FUNC_END_FRAME:
            begin
                // address advance only while rendering is enabled
                if (render_mask_q[MASK_RENDER_BIT])
                begin
                    if (vid_addr[7:0] < LINE_END_LOW)
                        vid_addr = vid_addr + ADDR_STEP;
                    else
                        vid_addr = (vid_addr ^ NT_TOGGLE) - LINE_WRAP_BACK;
                end
            end
            default: ;
        endcase
        res.addr = vid_addr;
        res.fx = fine_x_q;
    endtask

    // Track transfers: compare the oldest prediction first, then add the new one
    always @(posedge clk or negedge rst_n)
    begin
        port_result_t want;
        if (!rst_n)
        begin
            a12_mask_q = A12_MASK_RESET;
            ctrl_q = '0;
            render_mask_q = '0;
            status_q = STATUS_RESET;
            oam_ptr = '0;
            for (int i = 0; i < OAM_DEPTH; i++)
                oam_mem[i] = '0;
            toggle_q = 1'b0;
            tmp_addr = '0;
            vid_addr = '0;
            fine_x_q = '0;
            predicted_results.delete();
            errors = 0;
            checked_n = 0;
        end
        else
        begin
            if (cfg_wr_en)
                a12_mask_q = cfg_wr_data;
            if (out_valid && !out_stall)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch("result with nothing expected, addr",
                                    int'(current_addr), 0);
                else
                begin
                    want = predicted_results.pop_front();
                    if (read_data !== want.rd)
                        report_mismatch("read_data", int'(read_data), int'(want.rd));
                    if (a12_clock !== want.a12)
                        report_mismatch("a12_clock", int'(a12_clock), int'(want.a12));
                    if (nmi_request !== want.nmi)
                        report_mismatch("nmi_request", int'(nmi_request), int'(want.nmi));
                    if (current_addr !== want.addr)
                        report_mismatch("current_addr", int'(current_addr),
                                        int'(want.addr));
                    if (fine_scroll_x !== want.fx)
                        report_mismatch("fine_scroll_x", int'(fine_scroll_x),
                                        int'(want.fx));
                    checked_n++;
                end
            end
            if (in_valid && !in_stall)
            begin
                step_register_port(func, reg_index, data, want);
                predicted_results.push_back(want);
            end
        end
        pending <= predicted_results.size();
        mismatches <= errors;
        checked <= checked_n;
    end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the video scroll and sprite register port. A directed pass
// covers the register corners, then five phases of random register traffic
// run under different a12_mask settings with random idling on both channels,
// one long output hold-off and a final phase without idling. The checker
// module predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import vsp_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [2:0] REG_SPARE        = 3'd7;
    localparam logic [2:0] FUNC_SPARE_FIRST = 3'd5;
    localparam logic [2:0] FUNC_SPARE_LAST  = 3'd7;

    localparam int PHASE_ITEMS    = 300;
    localparam int HOLD_CYCLES    = 48;
    localparam int WATCHDOG_LIMIT = 1000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [14:0] cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  func = '0;
    logic [2:0]  reg_index = '0;
    logic [7:0]  data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  read_data;
    logic        a12_clock;
    logic        nmi_request;
    logic [14:0] current_addr;
    logic [2:0]  fine_scroll_x;

    int pending;
    int mismatches;
    int checked;
    int items_sent = 0;
    int mask_writes = 0;
    int quiet_cycles = 0;
    bit src_idle_on = 1'b0;
    bit sink_idle_on = 1'b0;
    bit long_hold_req = 1'b0;
    logic [14:0] mask_plan [5];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    video_scroll_and_oam_register_port_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .reg_index     (reg_index),
        .data          (data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .a12_clock     (a12_clock),
        .nmi_request   (nmi_request),
        .current_addr  (current_addr),
        .fine_scroll_x (fine_scroll_x)
    );

    vsp_port_checker port_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .reg_index     (reg_index),
        .data          (data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .read_data     (read_data),
        .a12_clock     (a12_clock),
        .nmi_request   (nmi_request),
        .current_addr  (current_addr),
        .fine_scroll_x (fine_scroll_x),
        .pending       (pending),
        .mismatches    (mismatches),
        .checked       (checked)
    );

    // Watchdog: ends the run after a long stretch with no transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_req = 1'b0;
                out_stall <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Byte with extra weight on the extremes
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(input logic [2:0] f, input logic [2:0] r, input logic [7:0] d);
        if (src_idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        reg_index <= r;
        data <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Stop offering and wait until every predicted result has come out
    task automatic drain_port();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_a12_mask(input logic [14:0] value);
        drain_port();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mask_writes++;
    endtask

    // Register corners: status clear-on-read, nmi, toggle, a12, frame end, sprites
    task automatic run_directed();
        send_item(FUNC_READ, REG_STATUS, 8'h00);
        send_item(FUNC_READ, REG_STATUS, 8'hFF);
        send_item(FUNC_WRITE, REG_CTRL, 8'hFF);
        send_item(FUNC_SET_STATUS, REG_CTRL, 8'h80);
        send_item(FUNC_SET_STATUS, REG_CTRL, 8'h7F);
        send_item(FUNC_PRERENDER, REG_SPARE, 8'hFF);
        send_item(FUNC_READ, REG_STATUS, 8'h00);
        send_item(FUNC_WRITE, REG_CTRL, 8'h00);
        // scroll pair leaves temp bit 14 set, then a lone second address write
        send_item(FUNC_WRITE, REG_SCROLL, 8'hFF);
        send_item(FUNC_WRITE, REG_SCROLL, 8'hFF);
        send_item(FUNC_WRITE, REG_SCROLL, 8'h00);
        send_item(FUNC_WRITE, REG_ADDR, 8'hFF);
        send_item(FUNC_WRITE, REG_ADDR, 8'hFF);
        send_item(FUNC_WRITE, REG_ADDR, 8'hFE);
        // frame end at the line wrap, in the middle, and with rendering off
        send_item(FUNC_WRITE, REG_MASK, 8'hFF);
        send_item(FUNC_END_FRAME, REG_CTRL, 8'h00);
        send_item(FUNC_END_FRAME, REG_SPARE, 8'hFF);
        send_item(FUNC_WRITE, REG_MASK, 8'h00);
        send_item(FUNC_END_FRAME, REG_CTRL, 8'h00);
        // sprite pointer wrap and the attribute byte mask
        send_item(FUNC_WRITE, REG_OAM_ADDR, 8'hFE);
        send_item(FUNC_WRITE, REG_OAM_DATA, 8'hFF);
        send_item(FUNC_WRITE, REG_OAM_DATA, 8'hFF);
        send_item(FUNC_WRITE, REG_OAM_ADDR, 8'hFE);
        send_item(FUNC_READ, REG_OAM_DATA, 8'h00);
        // registers and codes with no effect
        send_item(FUNC_READ, REG_CTRL, 8'h00);
        send_item(FUNC_WRITE, REG_STATUS, 8'hFF);
        send_item(FUNC_WRITE, REG_SPARE, 8'hFF);
        send_item(FUNC_READ, REG_SPARE, 8'h00);
        send_item(FUNC_SPARE_LAST, REG_STATUS, 8'hFF);
    endtask

    // One random register sequence, mostly well formed with random content
    task automatic issue_random_sequence();
        logic [7:0] base;
        logic [7:0] low_byte;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                if ($urandom_range(0, 2) == 0)
                    send_item(FUNC_READ, REG_STATUS, rand_byte());
                low_byte = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(252, 255))
                                                       : rand_byte();
                send_item(FUNC_WRITE, REG_ADDR, rand_byte());
                send_item(FUNC_WRITE, REG_ADDR, low_byte);
            end
            2:
            begin
                if ($urandom_range(0, 2) == 0)
                    send_item(FUNC_READ, REG_STATUS, rand_byte());
                send_item(FUNC_WRITE, REG_SCROLL, rand_byte());
                send_item(FUNC_WRITE, REG_SCROLL, rand_byte());
            end
            3:
            begin
                base = rand_byte();
                send_item(FUNC_WRITE, REG_OAM_ADDR, base);
                repeat ($urandom_range(1, 4))
                    send_item(FUNC_WRITE, REG_OAM_DATA, rand_byte());
                send_item(FUNC_WRITE, REG_OAM_ADDR, base + 8'($urandom_range(0, 3)));
                send_item(FUNC_READ, REG_OAM_DATA, rand_byte());
            end
            4:
            begin
                if ($urandom_range(0, 1) == 0)
                    send_item(FUNC_WRITE, REG_CTRL, rand_byte());
                else
                    send_item(FUNC_WRITE, REG_MASK,
                              rand_byte() | (($urandom_range(0, 2) != 0) ?
                                             (8'd1 << MASK_RENDER_BIT) : 8'd0));
            end
            5:
            begin
                send_item(FUNC_SET_STATUS, 3'($urandom_range(0, 7)), rand_byte());
                if ($urandom_range(0, 1) == 0)
                    send_item(FUNC_PRERENDER, 3'($urandom_range(0, 7)), rand_byte());
                send_item(FUNC_READ, REG_STATUS, rand_byte());
            end
            6:
            begin
                repeat ($urandom_range(1, 6))
                    send_item(FUNC_END_FRAME, 3'($urandom_range(0, 7)), rand_byte());
            end
            7: send_item(FUNC_READ, 3'($urandom_range(0, 7)), rand_byte());
            default:
            begin
                // noise: any item, now and then an unused function code
                if ($urandom_range(0, 15) == 0)
                    send_item(3'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST)),
                              3'($urandom_range(0, 7)), rand_byte());
                else
                    send_item(3'($urandom_range(FUNC_WRITE, FUNC_END_FRAME)),
                              3'($urandom_range(REG_CTRL, REG_SPARE)), rand_byte());
            end
        endcase
    endtask

    // Main sequence
    initial
    begin
        mask_plan[0] = 15'h0000;
        mask_plan[1] = 15'h7FFF;
        mask_plan[2] = 15'($urandom_range(0, 32767));
        mask_plan[3] = A12_MASK_RESET;
        mask_plan[4] = 15'($urandom_range(0, 32767));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int phase = 0; phase < 5; phase++)
        begin
            write_a12_mask(mask_plan[phase]);
            src_idle_on = (phase < 4);
            sink_idle_on = (phase < 4);
            // output held off while items keep coming, so the input backs up
            if (phase == 1)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; )
            begin
                n -= items_sent;
                issue_random_sequence();
                n += items_sent;
            end
        end

        drain_port();
        repeat (4) @(posedge clk);

        $display("Covered %0d register port items and %0d checked results over %0d a12 mask",
                 items_sent, checked, mask_writes + 1);
        $display("settings, with stall bursts, one long output hold-off and drained pauses.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: files.f
sv/vsp_pkg.sv
sv/vsp_oam_ram.sv
sv/vsp_regs.sv
sv/video_scroll_and_oam_register_port_unit.sv
sim/vsp_port_checker.sv
sim/tb_top.sv
